// ===== hdl/swa_pkg.sv =====
package swa_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int HIST_DEPTH = MAX_WINDOW - 1;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int WIN_W      = 7;
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(8);
  localparam logic [WIN_W-1:0]  WIN_MIN   = WIN_W'(2);
  localparam logic [WIN_W-1:0]  WIN_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(HIST_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_LAST,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/sliding_window_average_core.sv =====
// Moving average over the last n samples (n = window_length clamped to 2..64),
// truncated mean.
// Sequence: the history is read one entry a cycle, newest first, n - 1 entries;
// then the new sample is stored and the one-bit-a-cycle divide starts in the
// same cycle, and once the divide is done the result register is loaded. No
// new sample is taken until the result register has been loaded. A result
// still waiting on out_ready holds the block in the divide state.
// Reset (rst_n low, synchronous): history reads as zeros, newest slot 0,
// window_length 8, no result pending.
module sliding_window_average_core
  import swa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_average,
  input  logic                cfg_we,
  input  logic [WIN_W-1:0]    cfg_wdata
);

  state_t              state_r, state_nxt;
  logic [WIN_W-1:0]    win_len_r;
  logic [WIN_W-1:0]    eff_win;
  logic [WIN_W-1:0]    n_r;
  logic [ADDR_W-1:0]   pos_r, pos_inc;
  logic [ADDR_W-1:0]   rd_addr_r;
  logic [ADDR_W-1:0]   cnt_r;
  logic                rd_pend_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] cur_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;

  logic                in_acc;
  logic                rd_en;
  logic                wr_en;
  logic                div_start;
  logic                out_load;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] quotient;
  div_stat_t           div_stat;

  // Clamp the window to the supported range.
  always_comb begin
    eff_win = win_len_r;
    if (win_len_r < WIN_MIN) eff_win = WIN_MIN;
    if (win_len_r > WIN_MAX) eff_win = WIN_MAX;
  end

  assign pos_inc = (pos_r == ADDR_LAST) ? '0 : pos_r + 1'b1;
  assign in_acc  = in_valid && in_ready;

  // Fold in the entry read last cycle.
  assign sum_nxt = rd_pend_r ? sum_r + SUM_W'(rd_data) : sum_r;

  // Sequencer: read n-1 history entries newest first, then store the new
  // sample over the oldest slot and divide.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        rd_en = 1'b1;
        if (cnt_r == ADDR_W'(1)) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        // last read is in; the slot after newest is no longer needed
        wr_en     = 1'b1;
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // hold the quotient until the output register is free
        if (div_stat.done && (!out_valid_r || out_ready)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WIN_RESET;
      pos_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) win_len_r <= cfg_wdata;
      if (wr_en) pos_r <= pos_inc;
      rd_pend_r <= rd_en;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: item context, read pointer, running sum.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r     <= in_sample;
      sum_r     <= SUM_W'(in_sample);
      n_r       <= eff_win;
      cnt_r     <= ADDR_W'(eff_win - 1'b1);
      rd_addr_r <= pos_r;
    end else begin
      sum_r <= sum_nxt;
      if (rd_en) begin
        cnt_r     <= cnt_r - 1'b1;
        rd_addr_r <= (rd_addr_r == '0) ? ADDR_LAST : rd_addr_r - 1'b1;
      end
    end
    if (out_load) out_avg_r <= quotient;
  end

  swa_hist_mem u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (pos_inc),
    .wr_data (cur_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  swa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (n_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;

  // An accepted item always starts the history walk.
  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_ACC)
    else $error("accepted item did not start the history read");

  // A result only appears after the division finished.
  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DIV) && $past(div_stat.done))
    else $error("result presented without a finished division");

  // Divider never reports done while still stepping.
  a_div_stat: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> !div_stat.busy)
    else $error("divider done and busy at once");

  // The new sample is written only once all history reads are in.
  a_write_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> rd_pend_r && !rd_en)
    else $error("history write overlaps the read walk");

endmodule

// ===== hdl/swa_hist_mem.sv =====
module swa_hist_mem
  import swa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0]   mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] valid_r;
  logic [SAMPLE_W-1:0]   rd_data_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/swa_div.sv =====
module swa_div
  import swa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [WIN_W-1:0]    divisor,
  output logic [SAMPLE_W-1:0] quotient,
  output div_stat_t           stat
);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [WIN_W-1:0]  rem_r, rem_nxt;
  logic [WIN_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [WIN_W:0]    trial;
  logic              fits;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    fits    = trial >= {1'b0, dsr_r};
    rem_nxt = fits ? WIN_W'(trial - {1'b0, dsr_r}) : trial[WIN_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= STEP_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // mean never exceeds the sample range, so the low bits hold the whole result
  assign quotient  = quo_r[SAMPLE_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import swa_pkg::*;

  // Predicts the moving average of each accepted sample and holds the
  // averages still owed by the block, oldest first.
  class avg_scoreboard;
    logic [SAMPLE_W-1:0] history [HIST_DEPTH];
    logic [ADDR_W-1:0]   newest;
    logic [WIN_W-1:0]    window_reg;
    logic [SAMPLE_W-1:0] owed_avg [$];
    int unsigned         errors;

    function void clear();
      foreach (history[i]) history[i] = '0;
      newest     = '0;
      window_reg = WIN_RESET;
      owed_avg.delete();
      errors     = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      window_reg = value;
    endfunction

    function int unsigned pending();
      return owed_avg.size();
    endfunction

    // Sum the new sample with the span-1 newest stored ones, then store it.
    function void note_sample(logic [SAMPLE_W-1:0] sample);
      int unsigned span;
      int unsigned pos;
      int unsigned idx;
      int unsigned total;
      if (window_reg < WIN_MIN) begin
        span = WIN_MIN;
      end else if (window_reg > WIN_MAX) begin
        span = WIN_MAX;
      end else begin
        span = window_reg;
      end
      total = sample;
      pos   = newest;
      for (int k = 0; k + 1 < span; k++) begin
        idx   = (pos + HIST_DEPTH - k) % HIST_DEPTH;
        total += history[idx];
      end
      pos          = (pos + 1) % HIST_DEPTH;
      history[pos] = sample;
      newest       = ADDR_W'(pos);
      owed_avg.push_back(SAMPLE_W'(total / span));
    endfunction

    function void check_average(logic [SAMPLE_W-1:0] actual);
      logic [SAMPLE_W-1:0] want;
      if (owed_avg.size() == 0) begin
        $display("%0t: average %0d arrived with none expected", $time, actual);
        errors++;
        return;
      end
      want = owed_avg.pop_front();
      if (actual !== want) begin
        $display("%0t: average mismatch, expected %0d actual %0d", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES = 100;   // longer than the worst latency

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_ready;
  logic [SAMPLE_W-1:0] out_average;
  logic                cfg_we;
  logic [WIN_W-1:0]    cfg_wdata;

  avg_scoreboard sb;
  bit            quiet;        // when set, neither side idles
  int unsigned   idle_cycles = 0;

  sliding_window_average_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Feed the scoreboard from the handshakes seen at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_sample(in_sample);
      if (out_valid && out_ready)
        sb.check_average(out_average);
    end
  end

  // Abort when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one sample after a random gap and hold it until accepted.
  // Enter and leave just after a falling edge; in_valid stays high on exit
  // so a back-to-back item keeps it high without a glitch.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_sample = value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Take one average; on a stall, hold ready low for a few cycles after
  // valid shows up so back-pressure lands on a waiting result.
  task automatic take_average();
    int unsigned stall;
    stall = quiet ? 0 : $urandom_range(0, 3);
    if (stall == 0) begin
      out_ready = 1'b1;
    end else begin
      out_ready = 1'b0;
      do @(posedge clk); while (!out_valid);
      repeat (stall) @(negedge clk);
      out_ready = 1'b1;
    end
    do @(posedge clk); while (!(out_valid && out_ready));
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed average has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the window length while the block is idle.
  task automatic write_window(input logic [WIN_W-1:0] value);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_window(value);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] value;
    logic [WIN_W-1:0]    win;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample   = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    quiet       = 1'b0;
    sb          = new();
    sb.clear();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    fork
      forever take_average();
    join_none

    // Reset window of 8 over the cleared history: early averages see zeros.
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h0001);

    // Shortest legal window, full-scale and zero samples.
    write_window(WIN_MIN);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);

    // Longest window: reaches back over the whole stored history.
    write_window(WIN_MAX);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'hFFFF);

    // Window too short: zero and one both behave as two.
    write_window(WIN_W'(0));
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    write_window(WIN_W'(1));
    send_sample(16'hFFFE);
    send_sample(16'h0003);

    // Window too long: clamps to the maximum.
    write_window(WIN_MAX + 1'b1);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    write_window('1);
    send_sample(16'hFFFF);
    send_sample(16'h5555);

    // Random phases, each with its own window; drain and reconfigure between.
    for (int phase = 0; phase < 13; phase++) begin
      case ($urandom_range(0, 7))
        0:       win = WIN_MIN;
        1:       win = WIN_MAX;
        2:       win = WIN_W'($urandom_range(0, 1));
        3:       win = WIN_W'($urandom_range(MAX_WINDOW + 1, 127));
        default: win = WIN_W'($urandom_range(2, MAX_WINDOW));
      endcase
      write_window(win);
      quiet = (phase % 4 == 1);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0:       value = 16'h0000;
          1:       value = 16'hFFFF;
          2:       value = SAMPLE_W'($urandom_range(0, 15));
          3:       value = SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
          default: value = SAMPLE_W'($urandom);
        endcase
        send_sample(value);
      end
    end

    // Wait out the last averages, then let any stray output show up.
    quiet = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
